// ----- design/murmur3_word_stream_hash_top_defines.svh -----
// Assertion macros used by the word-stream hash top level.
`ifndef MURMUR3_WORD_STREAM_HASH_TOP_DEFINES_SVH
`define MURMUR3_WORD_STREAM_HASH_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define M3_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define M3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/m3wsh_pkg.sv -----
// Package: widths, hash constants, sequencer states and multiplier request type.
`default_nettype none
package m3wsh_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = WordW / 2;

  typedef logic [WordW-1:0] word_t;
  typedef logic [HalfW-1:0] half_t;

  localparam word_t MixK1    = 64'h87c3_7b91_1142_53d5;
  localparam word_t MixK2    = 64'h4cf5_ad43_2745_937f;
  localparam word_t AddOne   = 64'h0000_0000_52dc_e729;
  localparam word_t AddTwo   = 64'h0000_0000_3849_5ab5;
  localparam word_t FinM1    = 64'hff51_afd7_ed55_8ccd;
  localparam word_t FinM2    = 64'hc4ce_b9fe_1a85_ec53;
  localparam word_t BytesPerWord = 64'd8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_LANE,
    S_FIN0,
    S_FIN1,
    S_FX,
    S_FM1,
    S_FM2,
    S_ADD1,
    S_ADD2,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

endpackage
`default_nettype wire

// ----- design/m3wsh_stream_if.sv -----
// Stream interfaces: input word beats and output digest beats.
`default_nettype none
interface m3wsh_in_if;
  import m3wsh_pkg::*;
  logic  valid;
  logic  ready;
  word_t word;
  word_t seed;
  logic  first;
  logic  last;
  modport source (output valid, word, seed, first, last, input ready);
  modport sink   (input valid, word, seed, first, last, output ready);
endinterface

interface m3wsh_out_if;
  import m3wsh_pkg::*;
  logic  valid;
  logic  ready;
  word_t digest;
  modport source (output valid, digest, input ready);
  modport sink   (input valid, digest, output ready);
endinterface
`default_nettype wire

// ----- design/m3wsh_mul.sv -----
// Iterative 64x64 low-half multiplier built on one 32x32 multiplier.
`default_nettype none
module m3wsh_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  m3wsh_pkg::mul_req_t req_i,
  output logic               done_o,
  output m3wsh_pkg::word_t   p_o
);
  import m3wsh_pkg::*;

  word_t       a_q, b_q, acc_q, acc_d;
  logic [1:0]  step_q, step_d;
  logic        busy_q, busy_d, done_q, done_d;
  half_t       op_x, op_y;
  word_t       prod;

  // low*low, then high*low, then low*high cross terms
  assign op_x = (step_q == 2'd1) ? a_q[WordW-1:HalfW] : a_q[HalfW-1:0];
  assign op_y = (step_q == 2'd2) ? b_q[WordW-1:HalfW] : b_q[HalfW-1:0];
  assign prod = word_t'(op_x) * word_t'(op_y);

  always_comb begin
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      step_d = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (step_q == 2'd0) begin
        acc_d = prod;
      end else begin
        acc_d = acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};
      end
      step_d = step_q + 2'd1;
      if (step_q == 2'd2) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule
`default_nettype wire

// ----- design/murmur3_word_stream_hash_top.sv -----
// Top level: word-stream MurmurHash3 x64 sequencer around a shared multiplier.
//
//   channel | dir | payload                          | beat accepted when
//   --------+-----+----------------------------------+--------------------
//   in_i    | in  | word[64] seed[64] first[1] last[1] | valid & ready
//   out_o   | out | digest[64]                       | valid & ready
//
// Each word runs two 64-bit constant multiplies, each three passes through the one
// 32x32 multiplier plus a hand-off, then a lane update before the next accept.
// A last word adds four more multiplies for the two finalizers.
// Reset clears both lanes, the byte count and the word parity.
// The digest sits in an output register; the next message runs while it waits,
// and the sequencer holds in the emit step only if a new digest finds it full.
`default_nettype none
module murmur3_word_stream_hash_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  m3wsh_in_if.sink     in_i,
  m3wsh_out_if.source  out_o
);
  import m3wsh_pkg::*;
  `include "murmur3_word_stream_hash_top_defines.svh"

  // rotate left by a constant amount
  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

  // finalizer xor-shift step
  function automatic word_t xsh(word_t v);
    return v ^ (v >> 33);
  endfunction

  state_e   state_q, state_d;
  word_t    lane1_q, lane1_d, lane2_q, lane2_d;
  word_t    cnt_q, cnt_d;
  logic     odd_q, odd_d;
  logic     last_q, last_d;
  logic     sel_q, sel_d;
  word_t    digest_q, digest_d;
  logic     out_valid_q, out_valid_d;
  logic     in_beat, eff_odd;
  mul_req_t mul_req;
  logic     mul_done;
  word_t    mul_p;
  word_t    fin_lane;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_beat    = in_i.valid & in_i.ready;
  // a first word restarts the parity at even
  assign eff_odd    = in_i.first ? 1'b0 : odd_q;
  assign fin_lane   = sel_q ? lane2_q : lane1_q;

  m3wsh_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_beat) state_d = S_MUL1;
      S_MUL1: if (mul_done) state_d = S_MUL2;
      S_MUL2: if (mul_done) state_d = S_LANE;
      S_LANE: state_d = last_q ? S_FIN0 : S_IDLE;
      S_FIN0: state_d = S_FIN1;
      S_FIN1: state_d = S_FX;
      S_FX:   state_d = S_FM1;
      S_FM1:  if (mul_done) state_d = S_FM2;
      S_FM2:  if (mul_done) state_d = sel_q ? S_ADD1 : S_FX;
      S_ADD1: state_d = S_ADD2;
      S_ADD2: state_d = S_EMIT;
      S_EMIT: if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and multiplier requests
  always_comb begin
    lane1_d     = lane1_q;
    lane2_d     = lane2_q;
    cnt_d       = cnt_q;
    odd_d       = odd_q;
    last_d      = last_q;
    sel_d       = sel_q;
    digest_d    = digest_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    mul_req     = '{start: 1'b0, a: '0, b: '0};
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (in_i.first) begin
            lane1_d = in_i.seed;
            lane2_d = in_i.seed;
            cnt_d   = BytesPerWord;
          end else begin
            cnt_d = cnt_q + BytesPerWord;
          end
          odd_d   = eff_odd;
          last_d  = in_i.last;
          mul_req = '{start: 1'b1, a: in_i.word, b: (eff_odd ? MixK2 : MixK1)};
        end
      end
      S_MUL1: begin
        if (mul_done) begin
          mul_req = '{start: 1'b1,
                      a: (odd_q ? rotl(mul_p, 33) : rotl(mul_p, 31)),
                      b: (odd_q ? MixK1 : MixK2)};
        end
      end
      S_MUL2: begin
        if (mul_done) begin
          if (odd_q) begin
            lane2_d = rotl(lane2_q ^ mul_p, 31) + lane1_q;
          end else begin
            lane1_d = rotl(lane1_q ^ mul_p, 27) + lane2_q;
          end
        end
      end
      S_LANE: begin
        // times five plus constant, as shift-add
        if (odd_q) begin
          lane2_d = lane2_q + (lane2_q << 2) + AddTwo;
        end else begin
          lane1_d = lane1_q + (lane1_q << 2) + AddOne;
        end
        odd_d = ~odd_q;
      end
      S_FIN0: begin
        lane1_d = (lane1_q ^ cnt_q) + (lane2_q ^ cnt_q);
        lane2_d = lane2_q ^ cnt_q;
      end
      S_FIN1: begin
        lane2_d = lane2_q + lane1_q;
        sel_d   = 1'b0;
      end
      S_FX: begin
        mul_req = '{start: 1'b1, a: xsh(fin_lane), b: FinM1};
      end
      S_FM1: begin
        if (mul_done) begin
          mul_req = '{start: 1'b1, a: xsh(mul_p), b: FinM2};
        end
      end
      S_FM2: begin
        if (mul_done) begin
          if (sel_q) begin
            lane2_d = xsh(mul_p);
          end else begin
            lane1_d = xsh(mul_p);
          end
          sel_d = 1'b1;
        end
      end
      S_ADD1: lane1_d = lane1_q + lane2_q;
      S_ADD2: lane2_d = lane2_q + lane1_q;
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          digest_d    = lane1_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lane1_q     <= '0;
      lane2_q     <= '0;
      cnt_q       <= '0;
      odd_q       <= 1'b0;
      last_q      <= 1'b0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lane1_q     <= lane1_d;
      lane2_q     <= lane2_d;
      cnt_q       <= cnt_d;
      odd_q       <= odd_d;
      last_q      <= last_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digest_q <= digest_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.digest = digest_q;

  // multiplier results only land where the sequencer waits for them
  `M3_ASSERT_IMPL(a_done_in_wait, mul_done, (state_q == S_MUL1 || state_q == S_MUL2 || state_q == S_FM1 || state_q == S_FM2), "multiplier result outside a wait step")
  // a new digest only comes out of the emit step
  `M3_ASSERT_IMPL(a_digest_src, $rose(out_valid_q), ($past(state_q) == S_EMIT), "digest raised outside emit")
  // a non-final word returns straight to idle after the lane update
  `M3_ASSERT_NEXT(a_word_done, (state_q == S_LANE && !last_q), (state_q == S_IDLE), "non-final word did not return to idle")
  // every lane update flips the word parity
  `M3_ASSERT_NEXT(a_parity_flip, (state_q == S_LANE), (odd_q != $past(odd_q)), "word parity did not flip")

endmodule
`default_nettype wire
